// File: rtl/swlis_pkg.sv
// Package for the sliding-window increasing-subsequence length block.
// Holds field widths, reset values and the controller-to-datapath command type.
`timescale 1ns / 1ps
`default_nettype none
package swlis_pkg;
  localparam int SAMPLE_W        = 32;
  localparam int EXP_W           = 7;
  localparam int LEN_OUT_W       = 7;
  localparam int POS_OUT_W       = 6;
  localparam int WIN_W           = 7;
  localparam int DEF_MAX_WINDOW  = 64;
  localparam int DEF_VALUE_WIDTH = 32;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd64;
  localparam int PADDR_W         = 2;
  localparam logic [PADDR_W-1:0] REG_WINDOW_SIZE = 2'd0;

  typedef struct packed {
    logic load;
    logic expire;
    logic search;
    logic commit;
  } cmd_t;
endpackage
`default_nettype wire

// File: rtl/swlis_ctrl.sv
// Controller state machine: sequences expire, search and insert per transaction.
// Depends on swlis_pkg for the command struct.
`timescale 1ns / 1ps
`default_nettype none
module swlis_ctrl (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  output swlis_pkg::cmd_t  cmd
);
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXPIRE = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_INSERT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       commit;

  assign commit   = (state == ST_INSERT) && (!out_valid || !out_stall);
  assign in_stall = !((state == ST_IDLE) || commit);

  always_comb begin
    cmd.load   = in_valid && !in_stall;
    cmd.expire = (state == ST_EXPIRE);
    cmd.search = (state == ST_SEARCH);
    cmd.commit = commit;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXPIRE;
      end
      ST_EXPIRE: state_next = ST_SEARCH;
      ST_SEARCH: state_next = ST_INSERT;
      ST_INSERT: begin
        if (commit) state_next = in_valid ? ST_EXPIRE : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// File: rtl/swlis_dp.sv
// Datapath: register row of values and expiry counts with parallel expire,
// search and insert logic. Depends on swlis_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swlis_dp #(
  parameter int MAX_WINDOW  = swlis_pkg::DEF_MAX_WINDOW,
  parameter int VALUE_WIDTH = swlis_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire swlis_pkg::cmd_t                       cmd,
  input  wire logic [swlis_pkg::WIN_W-1:0]           window_size,
  input  wire logic signed [swlis_pkg::SAMPLE_W-1:0] sample_value,
  output logic [swlis_pkg::LEN_OUT_W-1:0]            lis_length,
  output logic [swlis_pkg::POS_OUT_W-1:0]            insert_position,
  output logic                                       entry_expired
);
  localparam int LW  = $clog2(MAX_WINDOW + 1);
  localparam int IW  = $clog2(MAX_WINDOW);
  localparam int LVL = $clog2(MAX_WINDOW);
  localparam int EW  = swlis_pkg::EXP_W;

  logic signed [VALUE_WIDTH-1:0] vals [MAX_WINDOW];
  logic [EW-1:0]                 exps [MAX_WINDOW];
  logic [LW-1:0]                 row_len;
  logic [EW-1:0]                 items_seen;
  logic signed [VALUE_WIDTH-1:0] key;
  logic [EW-1:0]                 new_d;
  logic                          expired;
  logic [LW-1:0]                 pos;

  logic [EW-1:0] win;
  logic [EW-1:0] seen_c;
  logic          do_exp;
  logic [EW-1:0] e_dec [MAX_WINDOW];
  logic          hit;
  logic [IW-1:0] zero_at;
  logic signed [VALUE_WIDTH-1:0] v_sh [MAX_WINDOW];
  logic [EW-1:0] e_sh [MAX_WINDOW];
  logic [LW-1:0] pos_next;
  logic [EW-1:0] pm [LVL+1][MAX_WINDOW];
  logic [EW-1:0] e_ins [MAX_WINDOW];
  logic [LW-1:0] len_new;
  logic [IW-1:0] idx;

  always_comb begin
    if (window_size == '0) win = EW'(1);
    else if (int'(window_size) > MAX_WINDOW) win = EW'(MAX_WINDOW);
    else win = window_size;
    seen_c = (items_seen > win) ? win : items_seen;
    do_exp = (seen_c >= win);
  end

  always_comb begin
    hit     = 1'b0;
    zero_at = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      e_dec[i] = exps[i];
      if (do_exp && i < int'(row_len) && exps[i] != '0) begin
        e_dec[i] = exps[i] - EW'(1);
        if (exps[i] == EW'(1)) begin
          hit     = 1'b1;
          zero_at = IW'(i);
        end
      end
    end
    for (int i = 0; i < MAX_WINDOW - 1; i++) begin
      if (do_exp && hit && i >= int'(zero_at)) begin
        v_sh[i] = vals[i+1];
        e_sh[i] = e_dec[i+1];
      end else begin
        v_sh[i] = vals[i];
        e_sh[i] = e_dec[i];
      end
    end
    v_sh[MAX_WINDOW-1] = vals[MAX_WINDOW-1];
    e_sh[MAX_WINDOW-1] = e_dec[MAX_WINDOW-1];
  end

  always_comb begin
    pos_next = row_len;
    for (int i = MAX_WINDOW - 1; i >= 0; i--) begin
      if (i < int'(row_len) && vals[i] > key) pos_next = LW'(i);
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_WINDOW; j++) begin
      pm[0][j] = (j >= int'(pos) && j < int'(row_len)) ? exps[j] : '0;
    end
    for (int k = 0; k < LVL; k++) begin
      for (int j = 0; j < MAX_WINDOW; j++) begin
        pm[k+1][j] = pm[k][j];
        if (j >= (1 << k) && pm[k][j-(1<<k)] > pm[k][j]) pm[k+1][j] = pm[k][j-(1<<k)];
      end
    end
    e_ins[0] = exps[0];
    for (int i = 1; i < MAX_WINDOW; i++) begin
      e_ins[i] = exps[i];
      if (i > int'(pos) && i < int'(row_len) && exps[i] > pm[LVL][i-1]) begin
        e_ins[i] = pm[LVL][i-1];
      end
    end
    len_new = row_len;
    idx     = IW'(pos);
    if (pos == row_len) begin
      if (int'(row_len) < MAX_WINDOW) len_new = row_len + LW'(1);
      else idx = IW'(MAX_WINDOW - 1);
    end
    e_ins[idx] = new_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_len    <= '0;
      items_seen <= '0;
    end else begin
      if (cmd.expire) begin
        items_seen <= (seen_c < win) ? seen_c + EW'(1) : seen_c;
        if (do_exp && hit) row_len <= row_len - LW'(1);
      end
      if (cmd.commit) row_len <= len_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) key <= VALUE_WIDTH'(sample_value);
    if (cmd.expire) begin
      new_d   <= (win > seen_c) ? seen_c + EW'(1) : win;
      expired <= do_exp && hit;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        vals[i] <= v_sh[i];
        exps[i] <= e_sh[i];
      end
    end
    if (cmd.search) pos <= pos_next;
    if (cmd.commit) begin
      for (int i = 0; i < MAX_WINDOW; i++) exps[i] <= e_ins[i];
      vals[idx]       <= key;
      lis_length      <= swlis_pkg::LEN_OUT_W'(len_new);
      insert_position <= swlis_pkg::POS_OUT_W'(idx);
      entry_expired   <= expired;
    end
  end
endmodule
`default_nettype wire

// File: rtl/sliding_window_lis_length.sv
// Top level of the sliding-window increasing-subsequence length block.
// Instantiates swlis_ctrl and swlis_dp; holds the APB window register. Uses swlis_pkg.
//
//  channel  direction  handshake            payload
//  input    in         in_valid / in_stall  sample_value
//  output   out        out_valid/out_stall  lis_length, insert_position, entry_expired
//  config   in         psel/penable/pready  paddr, pwdata, prdata (window_size)
//
// Each transaction steps through expire, search and insert over the register row.
// A new transaction is taken while idle or in the insert cycle that commits the last one.
// Synchronous reset empties the row and sets window_size to 64.
// A stalled result holds the insert cycle until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_lis_length #(
  parameter int MAX_WINDOW  = swlis_pkg::DEF_MAX_WINDOW,
  parameter int VALUE_WIDTH = swlis_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [swlis_pkg::PADDR_W-1:0]         paddr,
  input  wire logic [31:0]                           pwdata,
  output logic [31:0]                                prdata,
  output logic                                       pready,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [swlis_pkg::SAMPLE_W-1:0] sample_value,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [swlis_pkg::LEN_OUT_W-1:0]            lis_length,
  output logic [swlis_pkg::POS_OUT_W-1:0]            insert_position,
  output logic                                       entry_expired
);
  logic [swlis_pkg::WIN_W-1:0] window_size;
  swlis_pkg::cmd_t             cmd;
  logic                        reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr == swlis_pkg::REG_WINDOW_SIZE);
  assign prdata  = reg_hit ? 32'(window_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swlis_pkg::WINDOW_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      window_size <= pwdata[swlis_pkg::WIN_W-1:0];
    end
  end

  swlis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  swlis_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .window_size     (window_size),
    .sample_value    (sample_value),
    .lis_length      (lis_length),
    .insert_position (insert_position),
    .entry_expired   (entry_expired)
  );
endmodule
`default_nettype wire

// File: rtl/swlis_checker.sv
// Port-level checker for sliding_window_lis_length, attached by bind.
// Depends on swlis_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
module swlis_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  out_valid,
  input wire logic                                  out_stall,
  input wire logic [swlis_pkg::LEN_OUT_W-1:0]       lis_length,
  input wire logic [swlis_pkg::POS_OUT_W-1:0]       insert_position,
  input wire logic                                  entry_expired
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(lis_length) && $stable(insert_position)
      && $stable(entry_expired))
    else $error("stalled result changed");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lis_length != '0)
    else $error("empty row after insert");

  a_pos_in_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> swlis_pkg::LEN_OUT_W'(insert_position) < lis_length)
    else $error("insert position beyond row length");
endmodule

bind sliding_window_lis_length swlis_checker u_swlis_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .lis_length      (lis_length),
  .insert_position (insert_position),
  .entry_expired   (entry_expired)
);
`default_nettype wire

// File: test/sliding_window_lis_length_check.sv
// Checker for the sliding-window increasing-subsequence length block.
// Watches the APB port and both channels, predicts each result and compares it.
// Depends on swlis_pkg for the field widths.
`timescale 1ns / 1ps
module sliding_window_lis_length_check (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic                                  pready,
  input  logic [swlis_pkg::PADDR_W-1:0]         paddr,
  input  logic [31:0]                           pwdata,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [swlis_pkg::SAMPLE_W-1:0] sample_value,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic [swlis_pkg::LEN_OUT_W-1:0]       lis_length,
  input  logic [swlis_pkg::POS_OUT_W-1:0]       insert_position,
  input  logic                                  entry_expired,
  output int                                    pending,
  output int                                    errors
);
  localparam int ROW_DEPTH = swlis_pkg::DEF_MAX_WINDOW;

  typedef struct packed {
    logic [swlis_pkg::LEN_OUT_W-1:0] len;
    logic [swlis_pkg::POS_OUT_W-1:0] pos;
    logic                            expired;
  } lis_result_t;

  logic signed [swlis_pkg::SAMPLE_W-1:0] row_val [ROW_DEPTH];
  logic [swlis_pkg::EXP_W-1:0]           row_exp [ROW_DEPTH];
  int                                    row_len;
  int                                    seen;
  logic [swlis_pkg::WIN_W-1:0]           window;
  lis_result_t                           lis_queue[$];
  int                                    err_count = 0;

  assign pending = lis_queue.size();
  assign errors  = err_count;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic lis_result_t lis_update(input logic signed [swlis_pkg::SAMPLE_W-1:0] v);
    lis_result_t r;
    int w, zero_at, pos, new_d, carry, cur_max, t;
    bit found;
    w = (window == 0) ? 1 : (window > ROW_DEPTH) ? ROW_DEPTH : int'(window);
    found = 0;
    zero_at = 0;
    if (seen > w) seen = w;
    if (seen >= w) begin
      for (int i = 0; i < row_len; i++) begin
        if (row_exp[i] != 0) begin
          row_exp[i] = row_exp[i] - 1;
          if (row_exp[i] == 0) begin
            zero_at = i;
            found = 1;
          end
        end
      end
      if (found) begin
        for (int i = zero_at; i + 1 < row_len; i++) begin
          row_val[i] = row_val[i+1];
          row_exp[i] = row_exp[i+1];
        end
        row_len--;
      end
    end
    new_d = (w > seen) ? seen + 1 : w;
    pos = row_len;
    for (int i = row_len - 1; i >= 0; i--)
      if (row_val[i] > v) pos = i;
    if (pos == row_len) begin
      if (row_len < ROW_DEPTH) row_len++;
      else pos = ROW_DEPTH - 1;
    end else begin
      carry = row_exp[pos];
      cur_max = carry;
      for (int i = pos + 1; i < row_len; i++) begin
        if (row_exp[i] > cur_max) begin
          t = row_exp[i];
          cur_max = t;
          row_exp[i] = carry;
          carry = t;
        end
      end
    end
    row_val[pos] = v;
    row_exp[pos] = new_d[swlis_pkg::EXP_W-1:0];
    if (seen < w) seen++;
    r.len = row_len[swlis_pkg::LEN_OUT_W-1:0];
    r.pos = pos[swlis_pkg::POS_OUT_W-1:0];
    r.expired = found;
    return r;
  endfunction

  always @(posedge clk) begin
    lis_result_t want;
    if (rst) begin
      row_len = 0;
      seen = 0;
      window = swlis_pkg::WINDOW_RESET;
      lis_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == swlis_pkg::REG_WINDOW_SIZE)
        window = pwdata[swlis_pkg::WIN_W-1:0];
      if (in_valid && !in_stall) lis_queue = {lis_queue, lis_update(sample_value)};
      if (out_valid && !out_stall) begin
        if (lis_queue.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = lis_queue.pop_front();
          if (lis_length != want.len) report("lis_length", lis_length, want.len);
          if (insert_position != want.pos)
            report("insert_position", insert_position, want.pos);
          if (entry_expired != want.expired)
            report("entry_expired", entry_expired, want.expired);
        end
      end
    end
  end
endmodule

// File: test/sliding_window_lis_length_test.sv
// Testbench top for the sliding-window increasing-subsequence length block.
// Drives samples and window settings; uses sliding_window_lis_length_check and swlis_pkg.
`timescale 1ns / 1ps
module sliding_window_lis_length_test;
  localparam int STALL_LIMIT = 5000;

  logic                                  clk = 0;
  logic                                  rst = 1;
  logic                                  psel = 0, penable = 0, pwrite = 0;
  logic [swlis_pkg::PADDR_W-1:0]         paddr = '0;
  logic [31:0]                           pwdata = '0;
  logic [31:0]                           prdata;
  logic                                  pready;
  logic                                  in_valid = 0;
  logic                                  in_stall;
  logic signed [swlis_pkg::SAMPLE_W-1:0] sample_value = '0;
  logic                                  out_valid;
  logic                                  out_stall = 0;
  logic [swlis_pkg::LEN_OUT_W-1:0]       lis_length;
  logic [swlis_pkg::POS_OUT_W-1:0]       insert_position;
  logic                                  entry_expired;
  int                                    pending, errors;
  logic                                  in_took = 0;
  bit                                    quiet = 0;
  int                                    idle_cycles = 0;
  int                                    ramp = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  sliding_window_lis_length uut (.*);

  sliding_window_lis_length_check checker_i (.*);

  always @(posedge clk) begin
    in_took <= in_valid && !in_stall;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("sliding_window_lis_length_test failed");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        out_stall <= 1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 0;
    end
  end

  task automatic write_window(input logic [swlis_pkg::WIN_W-1:0] w);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= swlis_pkg::REG_WINDOW_SIZE;
    pwdata <= {25'($urandom()), w};
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic send(input logic signed [swlis_pkg::SAMPLE_W-1:0] v);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1;
    sample_value <= v;
    do @(negedge clk); while (!in_took);
  endtask

  function automatic logic signed [swlis_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom();
      2, 3, 4: return $signed($urandom_range(0, 40)) - 20;
      default: begin
        ramp = ($urandom_range(0, 30) == 0) ? $signed($urandom_range(0, 200)) - 100
                                             : ramp + $urandom_range(0, 3);
        return ramp;
      end
    endcase
  endfunction

  task automatic run_phase(input logic [swlis_pkg::WIN_W-1:0] w, input int count);
    drain();
    write_window(w);
    for (int i = 0; i < count; i++) send(pick_sample());
  endtask

  initial begin
    @(negedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    send(32'sh7fffffff);
    send(32'sh80000000);
    send(0);
    send(-1);
    send(-1);
    send(5);
    send(5);
    for (int i = 0; i < 8; i++) send(i * 3);
    for (int i = 0; i < 4; i++) send(100 - i);
    run_phase(1, 6);
    run_phase(0, 6);
    run_phase(127, 150);
    run_phase(2, 80);
    run_phase(64, 160);
    run_phase(3, 80);
    for (int p = 0; p < 10; p++) run_phase(swlis_pkg::WIN_W'($urandom_range(0, 127)), 90);
    // long increasing run fills the row
    drain();
    write_window(64);
    for (int i = 0; i < 140; i++) send(i);
    quiet = 1;
    run_phase(7, 100);
    drain();
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) $display("sliding_window_lis_length_test passed");
    else $display("sliding_window_lis_length_test failed");
    $finish;
  end
endmodule
